[rtl/sgdm_pkg.sv]
`default_nettype none
package sgdm_pkg;

  // Field widths
  localparam int IDX_W  = 12;
  localparam int DATA_W = 32;
  localparam int GAIN_W = 16;
  localparam int MODE_W = 2;

  // Packed stream widths, rounded up to whole bytes
  localparam int IN_TDATA_W  = ((IDX_W + 2 * DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = DATA_W;

  // Default depth of the history store
  localparam int HISTORY_DEPTH_DEF = 4096;

  // Index reduction uses a reciprocal scaled by 2^RECIP_SHIFT
  localparam int RECIP_SHIFT = 24;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_LEARNING_RATE = 2'd0;
  localparam logic [1:0] REG_MOMENTUM_GAIN = 2'd1;
  localparam logic [1:0] REG_DECAY_GAIN    = 2'd2;
  localparam logic [1:0] REG_REG_MODE      = 2'd3;

  // Regularization mode bits
  localparam int MODE_L1_BIT = 0;
  localparam int MODE_L2_BIT = 1;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic load;      // capture the accepted input item
    logic quot;      // estimate quotient, form decay product
    logic slot;      // finish index reduction
    logic read;      // read history entry, regularize gradient
    logic mul;       // form gain products
    logic acc;       // sum, round, saturate, write history back
    logic clear;     // write zero at the clear pointer
    logic out_load;  // load the result register
  } cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic clear_last;  // clear pointer at the last entry
    logic out_free;    // result register can take a new item
  } sts_t;

endpackage
`default_nettype wire

[rtl/sgdm_ctrl.sv]
`default_nettype none
module sgdm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire sgdm_pkg::sts_t sts,
  output sgdm_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_QUOT  = 3'd2;
  localparam logic [2:0] S_SLOT  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_ACC   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Step through one item, or sweep the store after reset
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_QUOT;
        end
      end
      S_QUOT: begin
        cmd.quot  = 1'b1;
        state_nxt = S_SLOT;
      end
      S_SLOT: begin
        cmd.slot  = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        cmd.read  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/sgdm_dp.sv]
`default_nettype none
module sgdm_dp #(
  parameter int HISTORY_DEPTH = sgdm_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire sgdm_pkg::cmd_t                      cmd,
  output sgdm_pkg::sts_t                           sts,
  input  wire logic [sgdm_pkg::IDX_W-1:0]          in_elem_index,
  input  wire logic signed [sgdm_pkg::DATA_W-1:0]  in_param_value,
  input  wire logic signed [sgdm_pkg::DATA_W-1:0]  in_grad_value,
  input  wire logic [sgdm_pkg::GAIN_W-1:0]         learning_rate,
  input  wire logic [sgdm_pkg::GAIN_W-1:0]         momentum_gain,
  input  wire logic [sgdm_pkg::GAIN_W-1:0]         decay_gain,
  input  wire logic [sgdm_pkg::MODE_W-1:0]         reg_mode,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic signed [sgdm_pkg::DATA_W-1:0]       out_new_param,
  output logic                                     out_saturated
);

  localparam int IDX_W   = sgdm_pkg::IDX_W;
  localparam int ADDR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int DEPTH_W = $clog2(HISTORY_DEPTH + 1);
  localparam int RECIP_W = sgdm_pkg::RECIP_SHIFT + 1;
  localparam int QP_W    = IDX_W + RECIP_W;
  localparam int QD_W    = IDX_W + DEPTH_W;
  localparam int unsigned RECIP = (1 << sgdm_pkg::RECIP_SHIFT) / HISTORY_DEPTH;
  localparam int PROD_W  = sgdm_pkg::GAIN_W + 1 + sgdm_pkg::DATA_W;

  // Clip a wide signed value to 32 bits; top bit flags a clip
  function automatic logic [32:0] sat36(input logic signed [35:0] v);
    logic [32:0] res;
    if (v > 36'sh07FFFFFFF) begin
      res = {1'b1, 32'h7FFFFFFF};
    end else if (v < 36'shF80000000) begin
      res = {1'b1, 32'h80000000};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

  logic [IDX_W-1:0]          idx_r;
  logic signed [31:0]        p_r;
  logic signed [31:0]        g_r;
  logic [IDX_W-1:0]          q_r;
  logic [ADDR_W-1:0]         slot_r;
  logic signed [PROD_W-1:0]  dp_r;
  logic signed [31:0]        rg_r;
  logic                      clip_r;
  logic signed [31:0]        hist_q;
  logic signed [PROD_W-1:0]  plr_r;
  logic signed [PROD_W-1:0]  pmg_r;
  logic signed [31:0]        h_r;
  logic [ADDR_W-1:0]         clr_cnt_r;
  logic                      out_valid_r;
  logic signed [31:0]        out_data_r;
  logic                      out_sat_r;

  logic signed [31:0]        mem [HISTORY_DEPTH];

  logic [QP_W-1:0]           qprod;
  logic [QD_W-1:0]           qd;
  logic [QD_W-1:0]           rem_raw;
  logic [QD_W-1:0]           rem_fix;
  logic signed [16:0]        d_s;
  logic signed [16:0]        lr_s;
  logic signed [16:0]        mg_s;
  logic signed [PROD_W-1:0]  dp_prod;
  logic signed [PROD_W-1:0]  l2_full;
  logic signed [16:0]        l1;
  logic signed [35:0]        l2_ext;
  logic signed [35:0]        rg_sum;
  logic [32:0]               rg_sat;
  logic signed [PROD_W:0]    hsum;
  logic [32:0]               h_sat;
  logic signed [32:0]        np_diff;
  logic [32:0]               np_sat;
  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_waddr;
  logic signed [31:0]        mem_wdata;

  // Index reduction: reciprocal estimate, then one correction
  assign qprod   = QP_W'(idx_r) * QP_W'(RECIP);
  assign qd      = QD_W'(q_r) * QD_W'(HISTORY_DEPTH);
  assign rem_raw = QD_W'(idx_r) - qd;
  assign rem_fix = (rem_raw >= QD_W'(HISTORY_DEPTH)) ? rem_raw - QD_W'(HISTORY_DEPTH)
                                                     : rem_raw;

  // Gains as non-negative signed operands
  assign d_s  = {1'b0, decay_gain};
  assign lr_s = {1'b0, learning_rate};
  assign mg_s = {1'b0, momentum_gain};
  assign dp_prod = PROD_W'(d_s) * PROD_W'(p_r);

  // Regularize the gradient
  assign l2_full = dp_r + PROD_W'(32768);
  always_comb begin
    l1 = '0;
    if (reg_mode[sgdm_pkg::MODE_L1_BIT]) begin
      if (p_r > 0) l1 = d_s;
      else if (p_r < 0) l1 = -d_s;
    end
    l2_ext = '0;
    if (reg_mode[sgdm_pkg::MODE_L2_BIT]) l2_ext = 36'($signed(l2_full[PROD_W-1:16]));
  end
  assign rg_sum = 36'(g_r) + 36'(l1) + l2_ext;
  assign rg_sat = sat36(rg_sum);

  // New history, rounded to nearest with ties up
  assign hsum  = (PROD_W + 1)'(plr_r) + (PROD_W + 1)'(pmg_r) + (PROD_W + 1)'(32768);
  assign h_sat = sat36(36'($signed(hsum[PROD_W:16])));

  // New parameter
  assign np_diff = 33'(p_r) - 33'(h_r);
  assign np_sat  = sat36(36'(np_diff));

  // Store write port: clearing sweep or history write-back
  assign mem_we    = cmd.clear | cmd.acc;
  assign mem_waddr = cmd.clear ? clr_cnt_r : slot_r;
  assign mem_wdata = cmd.clear ? 32'sd0 : $signed(h_sat[31:0]);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.read) hist_q <= mem[slot_r];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r <= in_elem_index;
      p_r   <= in_param_value;
      g_r   <= in_grad_value;
    end
    if (cmd.quot) begin
      q_r  <= qprod[sgdm_pkg::RECIP_SHIFT +: IDX_W];
      dp_r <= dp_prod;
    end
    if (cmd.slot) slot_r <= rem_fix[ADDR_W-1:0];
    if (cmd.read) begin
      rg_r   <= $signed(rg_sat[31:0]);
      clip_r <= rg_sat[32];
    end
    if (cmd.mul) begin
      plr_r <= PROD_W'(lr_s) * PROD_W'(rg_r);
      pmg_r <= PROD_W'(mg_s) * PROD_W'(hist_q);
    end
    if (cmd.acc) begin
      h_r    <= $signed(h_sat[31:0]);
      clip_r <= clip_r | h_sat[32];
    end
    if (cmd.out_load) begin
      out_data_r <= $signed(np_sat[31:0]);
      out_sat_r  <= clip_r | np_sat[32];
    end
  end

  // Clear pointer and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign sts.clear_last = (clr_cnt_r == ADDR_W'(HISTORY_DEPTH - 1));
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_new_param = out_data_r;
  assign out_saturated = out_sat_r;

endmodule
`default_nettype wire

[rtl/sgd_momentum_weight_decay_update.sv]
`default_nettype none
// SGD step with momentum and weight decay on a stream of parameter elements, signed
// Q16.16 data and unsigned Q0.16 gains. Each input item gives an element index, the
// parameter and its gradient; one result item returns the updated parameter and a flag
// that is set when any intermediate or final value was clipped to 32 bits. The index is
// reduced modulo HISTORY_DEPTH and selects a history entry held in an on-chip memory.
// After reset the block sweeps the history store to zero, one entry per cycle, with
// in_tready low; configuration writes are taken meanwhile. A new item is accepted only
// once the previous result has been loaded: the sequencer walks index reduction, the
// history read, the gain multiplies and the round-and-write-back in turn. A result
// waiting on out_tready holds the next item in its last step only. Write configuration
// only while no item is in flight.
module sgd_momentum_weight_decay_update #(
  parameter int HISTORY_DEPTH = sgdm_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // in_tdata: elem_index[11:0], param_value[43:12], grad_value[75:44], zero pad
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic [sgdm_pkg::IN_TDATA_W-1:0]       in_tdata,
  // out_tdata: new_param[31:0]
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic [sgdm_pkg::OUT_TDATA_W-1:0]           out_tdata,
  // out_tuser: saturated[0]
  output logic                                       out_tuser,
  input  wire logic                                  cfg_psel,
  input  wire logic                                  cfg_penable,
  input  wire logic                                  cfg_pwrite,
  input  wire logic [3:0]                            cfg_paddr,
  input  wire logic [31:0]                           cfg_pwdata,
  output logic [31:0]                                cfg_prdata,
  output logic                                       cfg_pready
);

  localparam int IDX_W  = sgdm_pkg::IDX_W;
  localparam int DATA_W = sgdm_pkg::DATA_W;
  localparam int GAIN_W = sgdm_pkg::GAIN_W;
  localparam int MODE_W = sgdm_pkg::MODE_W;

  logic [GAIN_W-1:0] learning_rate_r;
  logic [GAIN_W-1:0] momentum_gain_r;
  logic [GAIN_W-1:0] decay_gain_r;
  logic [MODE_W-1:0] reg_mode_r;
  logic              cfg_wr;
  logic [1:0]        cfg_sel;

  sgdm_pkg::cmd_t    cmd;
  sgdm_pkg::sts_t    sts;
  logic signed [DATA_W-1:0] new_param;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_sel    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learning_rate_r <= GAIN_W'(655);
      momentum_gain_r <= '0;
      decay_gain_r    <= '0;
      reg_mode_r      <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        sgdm_pkg::REG_LEARNING_RATE: learning_rate_r <= cfg_pwdata[GAIN_W-1:0];
        sgdm_pkg::REG_MOMENTUM_GAIN: momentum_gain_r <= cfg_pwdata[GAIN_W-1:0];
        sgdm_pkg::REG_DECAY_GAIN:    decay_gain_r    <= cfg_pwdata[GAIN_W-1:0];
        sgdm_pkg::REG_REG_MODE:      reg_mode_r      <= cfg_pwdata[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (cfg_sel)
      sgdm_pkg::REG_LEARNING_RATE: cfg_prdata = 32'(learning_rate_r);
      sgdm_pkg::REG_MOMENTUM_GAIN: cfg_prdata = 32'(momentum_gain_r);
      sgdm_pkg::REG_DECAY_GAIN:    cfg_prdata = 32'(decay_gain_r);
      sgdm_pkg::REG_REG_MODE:      cfg_prdata = 32'(reg_mode_r);
      default:                     cfg_prdata = '0;
    endcase
  end

  sgdm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sgdm_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_elem_index  (in_tdata[IDX_W-1:0]),
    .in_param_value ($signed(in_tdata[IDX_W +: DATA_W])),
    .in_grad_value  ($signed(in_tdata[IDX_W + DATA_W +: DATA_W])),
    .learning_rate  (learning_rate_r),
    .momentum_gain  (momentum_gain_r),
    .decay_gain     (decay_gain_r),
    .reg_mode       (reg_mode_r),
    .out_ready      (out_tready),
    .out_valid      (out_tvalid),
    .out_new_param  (new_param),
    .out_saturated  (out_tuser)
  );

  assign out_tdata = new_param;

  // An accepted item closes the input until its result is done
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in flight");

  // The clearing sweep holds the input closed right after reset
  a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_tready)
    else $error("input open before history store was cleared");

  // Hold a waiting result unchanged until it is taken
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("waiting result changed");

endmodule
`default_nettype wire
